FILE: rtl/ezvad_pkg.sv
// Shared types and constants for the energy / zero-crossing voice activity detector.
// Holds register index codes, reset values and the structs passed between modules.
// No dependencies.
package ezvad_pkg;

    localparam int ENERGY_THR_W = 31;
    localparam int RATE_THR_W   = 17;
    localparam int RUN_W        = 8;
    localparam int CFG_DATA_W   = 31;
    localparam int REG_IDX_W    = 2;
    localparam int OUT_DATA_W   = 8;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

    localparam logic [ENERGY_THR_W-1:0] ENERGY_THR_RESET = 31'd1073742;
    localparam logic [RATE_THR_W-1:0]   RATE_THR_RESET   = 17'd19661;
    localparam logic [RUN_W-1:0]        MIN_VOICED_RESET = 8'd3;
    localparam logic [RUN_W-1:0]        MIN_SILENT_RESET = 8'd10;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ENERGY_THR = 2'd0,
        REG_RATE_THR   = 2'd1,
        REG_MIN_VOICED = 2'd2,
        REG_MIN_SILENT = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [ENERGY_THR_W-1:0] energy_thr;
        logic [RATE_THR_W-1:0]   rate_thr;
        logic [RUN_W-1:0]        min_voiced;
        logic [RUN_W-1:0]        min_silent;
    } cfg_t;

    // Frame summary control: valid marks a closed frame, single a one-sample frame.
    typedef struct packed {
        logic valid;
        logic single;
    } frame_ctrl_t;

endpackage

FILE: rtl/ezvad_frame_acc.sv
// Per-frame accumulation: input register, squaring, crossing and sample counters,
// energy sum and the threshold products for the frame-end tests.
// Depends on ezvad_pkg.
module ezvad_frame_acc #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_FRAME   = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [SAMPLE_BITS-1:0]          in_sample,
    input  logic                            in_last,
    input  ezvad_pkg::cfg_t                 cfg,
    output ezvad_pkg::frame_ctrl_t          sum_ctrl,
    output logic [2*SAMPLE_BITS-3+$clog2(MAX_FRAME+1):0] energy_total,
    output logic [ezvad_pkg::ENERGY_THR_W+$clog2(MAX_FRAME+1)-1:0] energy_limit,
    output logic [$clog2(MAX_FRAME+1)+15:0] crossing_scaled,
    output logic [ezvad_pkg::RATE_THR_W+$clog2(MAX_FRAME+1)-1:0] crossing_limit
);

    localparam int CNT_W    = $clog2(MAX_FRAME + 1);
    localparam int SQ_W     = 2 * SAMPLE_BITS - 1;
    localparam int ENERGY_W = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int EPROD_W  = ezvad_pkg::ENERGY_THR_W + CNT_W;
    localparam int RPROD_W  = ezvad_pkg::RATE_THR_W + CNT_W;

    // stage 1: input register
    logic                   v1_reg;
    logic [SAMPLE_BITS-1:0] smp1_reg;
    logic                   last1_reg;

    // frame counters
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cross_reg, cross_next;
    logic             prev_neg_reg, prev_neg_next;

    // stage 2
    logic             v2_reg, last2_reg, take2_reg;
    logic [SQ_W-1:0]  sq2_reg;
    logic [CNT_W-1:0] n2_reg, x2_reg;

    // stage 3
    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic                v3_reg, single3_reg;
    logic [ENERGY_W-1:0] etot3_reg;
    logic [EPROD_W-1:0]  eprod3_reg;
    logic [CNT_W+15:0]   xs3_reg;
    logic [RPROD_W-1:0]  rprod3_reg;

    logic                         neg1;
    logic                         take1;
    logic                         cross_inc;
    logic [CNT_W-1:0]             n_total;
    logic [CNT_W-1:0]             x_total;
    logic signed [2*SAMPLE_BITS-1:0] sq_full;
    logic [ENERGY_W-1:0]          e_add;

    always_comb
    begin
        neg1      = smp1_reg[SAMPLE_BITS-1];
        take1     = cnt_reg < CNT_W'(MAX_FRAME);
        cross_inc = take1 && (cnt_reg != '0) && (neg1 != prev_neg_reg);
        n_total   = take1 ? cnt_reg + CNT_W'(1) : cnt_reg;
        x_total   = cross_reg + CNT_W'(cross_inc);
        sq_full   = $signed(smp1_reg) * $signed(smp1_reg);
        e_add     = energy_reg + (take2_reg ? ENERGY_W'(sq2_reg) : ENERGY_W'(0));
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        cross_next    = cross_reg;
        prev_neg_next = prev_neg_reg;
        energy_next   = energy_reg;
        if (en && v1_reg)
        begin
            if (last1_reg)
            begin
                cnt_next      = '0;
                cross_next    = '0;
                prev_neg_next = 1'b0;
            end
            else
            begin
                cnt_next   = n_total;
                cross_next = x_total;
                if (take1)
                begin
                    prev_neg_next = neg1;
                end
            end
        end
        if (en && v2_reg)
        begin
            energy_next = last2_reg ? '0 : e_add;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            cnt_reg      <= '0;
            cross_reg    <= '0;
            prev_neg_reg <= 1'b0;
            energy_reg   <= '0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            cross_reg    <= cross_next;
            prev_neg_reg <= prev_neg_next;
            energy_reg   <= energy_next;
            if (en)
            begin
                v1_reg <= in_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg && last2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (in_valid)
            begin
                smp1_reg  <= in_sample;
                last1_reg <= in_last;
            end
            last2_reg   <= last1_reg;
            take2_reg   <= take1;
            sq2_reg     <= sq_full[SQ_W-1:0];
            n2_reg      <= n_total;
            x2_reg      <= x_total;
            etot3_reg   <= e_add;
            eprod3_reg  <= EPROD_W'(cfg.energy_thr) * EPROD_W'(n2_reg);
            xs3_reg     <= {x2_reg, 16'h0000};
            rprod3_reg  <= RPROD_W'(cfg.rate_thr) * RPROD_W'(n2_reg - CNT_W'(1));
            single3_reg <= n2_reg < CNT_W'(2);
        end
    end

    assign sum_ctrl.valid   = v3_reg;
    assign sum_ctrl.single  = single3_reg;
    assign energy_total     = etot3_reg;
    assign energy_limit     = eprod3_reg;
    assign crossing_scaled  = xs3_reg;
    assign crossing_limit   = rprod3_reg;

endmodule

FILE: rtl/ezvad_decide.sv
// Frame-end decision: energy and crossing-rate tests, voiced/silent run counters,
// speech state and the output register. Depends on ezvad_pkg.
module ezvad_decide #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_FRAME   = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            out_ready,
    input  ezvad_pkg::cfg_t                 cfg,
    input  ezvad_pkg::frame_ctrl_t          sum_ctrl,
    input  logic [2*SAMPLE_BITS-3+$clog2(MAX_FRAME+1):0] energy_total,
    input  logic [ezvad_pkg::ENERGY_THR_W+$clog2(MAX_FRAME+1)-1:0] energy_limit,
    input  logic [$clog2(MAX_FRAME+1)+15:0] crossing_scaled,
    input  logic [ezvad_pkg::RATE_THR_W+$clog2(MAX_FRAME+1)-1:0] crossing_limit,
    output logic                            out_valid,
    output logic                            out_in_speech,
    output logic                            out_voiced
);

    localparam int CNT_W    = $clog2(MAX_FRAME + 1);
    localparam int ENERGY_W = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int EPROD_W  = ezvad_pkg::ENERGY_THR_W + CNT_W;
    localparam int ECMP_W   = (ENERGY_W > EPROD_W) ? ENERGY_W : EPROD_W;
    localparam int RPROD_W  = ezvad_pkg::RATE_THR_W + CNT_W;

    logic [ezvad_pkg::RUN_W-1:0] voiced_run_reg, voiced_run_next;
    logic [ezvad_pkg::RUN_W-1:0] silent_run_reg, silent_run_next;
    logic                        speech_reg, speech_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_speech_reg, out_voiced_reg;

    logic load;
    logic energy_ok;
    logic rate_ok;
    logic voiced;

    always_comb
    begin
        load      = sum_ctrl.valid && en;
        energy_ok = ECMP_W'(energy_total) > ECMP_W'(energy_limit);
        if (sum_ctrl.single)
        begin
            rate_ok = cfg.rate_thr != '0;
        end
        else
        begin
            rate_ok = RPROD_W'(crossing_scaled) < crossing_limit;
        end
        voiced = energy_ok && rate_ok;
    end

    always_comb
    begin
        voiced_run_next = voiced_run_reg;
        silent_run_next = silent_run_reg;
        speech_next     = speech_reg;
        if (load)
        begin
            if (voiced)
            begin
                if (voiced_run_reg != ezvad_pkg::RUN_MAX)
                begin
                    voiced_run_next = voiced_run_reg + 8'd1;
                end
                silent_run_next = '0;
                if (voiced_run_next >= cfg.min_voiced)
                begin
                    speech_next = 1'b1;
                end
            end
            else
            begin
                if (silent_run_reg != ezvad_pkg::RUN_MAX)
                begin
                    silent_run_next = silent_run_reg + 8'd1;
                end
                voiced_run_next = '0;
                if (silent_run_next >= cfg.min_silent)
                begin
                    speech_next = 1'b0;
                end
            end
        end
        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voiced_run_reg <= '0;
            silent_run_reg <= '0;
            speech_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            voiced_run_reg <= voiced_run_next;
            silent_run_reg <= silent_run_next;
            speech_reg     <= speech_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_speech_reg <= speech_next;
            out_voiced_reg <= voiced;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_in_speech = out_speech_reg;
    assign out_voiced    = out_voiced_reg;

endmodule

FILE: rtl/energy_zcr_voice_activity_detector.sv
// Energy and zero-crossing voice activity detector: top level with the configuration
// registers. Depends on ezvad_pkg, ezvad_frame_acc and ezvad_decide.
//
// The block takes one sample per clock and emits one result per frame: a transfer
// with s_tlast high closes the frame, and its result (in_speech, frame_voiced) passes
// stages one to three and the output register to the master side. Frames are summed
// as they stream in; a frame longer than MAX_FRAME samples keeps only its first
// MAX_FRAME samples, but its tlast still closes it. The rate is one sample per cycle
// while s_tready is high, set by the per-sample square-and-add; s_tready falls only
// while a finished frame result sits in stage three and the output register still
// holds an untaken one. Registers reset to their documented values and no clearing
// pass runs after reset. Write the configuration only while no frame result is pending.
module energy_zcr_voice_activity_detector #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_FRAME   = 1024
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // slave side
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,   // sample
    input  logic                                    s_tlast,   // frame_end
    // master side
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [ezvad_pkg::OUT_DATA_W-1:0]        m_tdata,   // in_speech, frame_voiced
    // configuration writes
    input  logic                                    cfg_we,
    input  logic [ezvad_pkg::REG_IDX_W-1:0]         cfg_index,
    input  logic [ezvad_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    localparam int CNT_W    = $clog2(MAX_FRAME + 1);
    localparam int ENERGY_W = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int EPROD_W  = ezvad_pkg::ENERGY_THR_W + CNT_W;
    localparam int RPROD_W  = ezvad_pkg::RATE_THR_W + CNT_W;

    ezvad_pkg::cfg_t cfg_reg, cfg_next;

    ezvad_pkg::frame_ctrl_t sum_ctrl;
    logic [ENERGY_W-1:0]    energy_total;
    logic [EPROD_W-1:0]     energy_limit;
    logic [CNT_W+15:0]      crossing_scaled;
    logic [RPROD_W-1:0]     crossing_limit;

    logic en;
    logic out_valid;
    logic out_in_speech;
    logic out_voiced;

    // register writes, no read-back
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ezvad_pkg::REG_ENERGY_THR: cfg_next.energy_thr = cfg_wdata;
                ezvad_pkg::REG_RATE_THR:   cfg_next.rate_thr   = cfg_wdata[16:0];
                ezvad_pkg::REG_MIN_VOICED: cfg_next.min_voiced = cfg_wdata[7:0];
                ezvad_pkg::REG_MIN_SILENT: cfg_next.min_silent = cfg_wdata[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.energy_thr <= ezvad_pkg::ENERGY_THR_RESET;
            cfg_reg.rate_thr   <= ezvad_pkg::RATE_THR_RESET;
            cfg_reg.min_voiced <= ezvad_pkg::MIN_VOICED_RESET;
            cfg_reg.min_silent <= ezvad_pkg::MIN_SILENT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // whole pipeline advances unless a frame result cannot enter the output register
    assign en       = !(sum_ctrl.valid && out_valid && !m_tready);
    assign s_tready = en;

    ezvad_frame_acc #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_FRAME   (MAX_FRAME)
    ) u_acc (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (s_tvalid),
        .in_sample       (s_tdata[SAMPLE_BITS-1:0]),
        .in_last         (s_tlast),
        .cfg             (cfg_reg),
        .sum_ctrl        (sum_ctrl),
        .energy_total    (energy_total),
        .energy_limit    (energy_limit),
        .crossing_scaled (crossing_scaled),
        .crossing_limit  (crossing_limit)
    );

    ezvad_decide #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_FRAME   (MAX_FRAME)
    ) u_decide (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .out_ready       (m_tready),
        .cfg             (cfg_reg),
        .sum_ctrl        (sum_ctrl),
        .energy_total    (energy_total),
        .energy_limit    (energy_limit),
        .crossing_scaled (crossing_scaled),
        .crossing_limit  (crossing_limit),
        .out_valid       (out_valid),
        .out_in_speech   (out_in_speech),
        .out_voiced      (out_voiced)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {6'b000000, out_voiced, out_in_speech};

endmodule

FILE: rtl/ezvad_checker.sv
// Port-level checks for the voice activity detector, bound to the top level.
// Depends on energy_zcr_voice_activity_detector ports only.
module ezvad_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input stalls only behind a blocked output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:2] == 6'b000000)
        else $error("nonzero padding in result");

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind energy_zcr_voice_activity_detector ezvad_checker u_ezvad_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
